// ----- design/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    localparam int COUNT_BITS = 20;

    localparam int TRIG_W   = 8;
    localparam int TMO_W    = 20;
    localparam int DIST_W   = 23;
    localparam int CFG_W    = 23;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_THRESH   = 2'd2;

    localparam logic [TRIG_W-1:0] TRIG_RESET   = 8'd10;
    localparam logic [TMO_W-1:0]  TMO_RESET    = 20'd30000;
    localparam logic [DIST_W-1:0] THRESH_RESET = 23'd102400;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_RISE   = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [1:0] ST_BELOW_MIN = 2'd3;

    localparam int          DIST_MUL   = 1124;
    localparam int          DIST_SHIFT = 8;
    localparam int          DIST_MIN   = 512;
    localparam int          DIST_MAX   = 8388607;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } t_in_item;

    typedef struct packed {
        logic              trigger_out;
        logic              busy_res;
        logic              done_res;
        logic [1:0]        status;
        logic [DIST_W-1:0] distance;
        logic              over_threshold;
    } t_out_item;

    // Outcome of one tick as seen by the sequencer.
    typedef struct packed {
        logic                  trigger;
        logic                  busy;
        logic                  done;
        logic                  meas_end;
        logic [1:0]            fail_status;
        logic [COUNT_BITS-1:0] width;
    } t_step;

endpackage

// ----- design/uer_ctrl.sv -----
// Measurement sequencer: trigger pulse, settle, echo rise wait and echo width count.
module uer_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  uer_pkg::t_in_item        i_item,
    input  logic [uer_pkg::TRIG_W-1:0] i_trigger_width,
    input  logic [uer_pkg::TMO_W-1:0]  i_timeout,
    output uer_pkg::t_step           o_step
);
    import uer_pkg::*;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TRIG      = 3'd1;
    localparam logic [2:0] PH_SETTLE    = 3'd2;
    localparam logic [2:0] PH_WAIT_RISE = 3'd3;
    localparam logic [2:0] PH_MEASURE   = 3'd4;

    localparam int CMP_W = (COUNT_BITS > TMO_W) ? COUNT_BITS : TMO_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;
    localparam logic [COUNT_BITS-1:0] SETTLE_END = COUNT_BITS'(2);

    logic [2:0]            r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  inc_timeout;
    logic                  trig_end;

    assign cnt_inc     = (r_count == CNT_MAX) ? CNT_MAX : r_count + 1'b1;
    assign inc_timeout = CMP_W'(cnt_inc) > CMP_W'(i_timeout);
    assign trig_end    = CMP_W'(r_count) >= CMP_W'(i_trigger_width);

    always_comb begin
        n_phase            = r_phase;
        n_count            = r_count;
        o_step.done        = 1'b0;
        o_step.meas_end    = 1'b0;
        o_step.fail_status = ST_OK;
        o_step.width       = r_count;
        case (r_phase)
            PH_IDLE: begin
                if (i_item.start_req) begin
                    n_phase = PH_TRIG;
                    n_count = COUNT_BITS'(1);
                end
            end
            PH_TRIG: begin
                if (trig_end) begin
                    n_phase = PH_SETTLE;
                    n_count = '0;
                end else begin
                    n_count = cnt_inc;
                end
            end
            PH_SETTLE: begin
                n_count = cnt_inc;
                if (cnt_inc >= SETTLE_END) begin
                    n_phase = PH_WAIT_RISE;
                    n_count = '0;
                end
            end
            PH_WAIT_RISE: begin
                if (i_item.echo_level) begin
                    n_phase = PH_MEASURE;
                    n_count = COUNT_BITS'(1);
                end else begin
                    n_count = cnt_inc;
                    if (inc_timeout) begin
                        o_step.done        = 1'b1;
                        o_step.fail_status = ST_NO_RISE;
                        n_phase            = PH_IDLE;
                        n_count            = '0;
                    end
                end
            end
            PH_MEASURE: begin
                if (i_item.echo_level) begin
                    n_count = cnt_inc;
                    if (inc_timeout) begin
                        o_step.done        = 1'b1;
                        o_step.fail_status = ST_TOO_LONG;
                        n_phase            = PH_IDLE;
                        n_count            = '0;
                    end
                end else begin
                    o_step.done     = 1'b1;
                    o_step.meas_end = 1'b1;
                    n_phase         = PH_IDLE;
                    n_count         = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase
        o_step.trigger = (n_phase == PH_TRIG);
        o_step.busy    = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

// ----- design/uer_dist.sv -----
// Echo width to distance conversion, minimum check and threshold flag.
module uer_dist (
    input  uer_pkg::t_step                i_step,
    input  logic [uer_pkg::DIST_W-1:0]    i_threshold,
    output uer_pkg::t_out_item            o_item
);
    import uer_pkg::*;

    localparam int MUL_W = 11;
    localparam int PW    = COUNT_BITS + MUL_W;
    localparam int DW    = PW - DIST_SHIFT;
    localparam int CW    = (DW > DIST_W) ? DW : DIST_W;

    logic [PW-1:0]     prod;
    logic [CW-1:0]     d_ext;
    logic [DIST_W-1:0] dist_val;
    logic              below_min;

    // The width is scaled by 1124/256, which gives the distance in units of 1/256 cm.
    assign prod      = PW'(i_step.width) * PW'(DIST_MUL);
    assign d_ext     = CW'(prod[PW-1:DIST_SHIFT]);
    assign dist_val  = (d_ext > CW'(DIST_MAX)) ? DIST_W'(DIST_MAX) : d_ext[DIST_W-1:0];
    assign below_min = dist_val < DIST_W'(DIST_MIN);

    always_comb begin
        o_item.trigger_out    = i_step.trigger;
        o_item.busy_res       = i_step.busy;
        o_item.done_res       = i_step.done;
        o_item.status         = i_step.fail_status;
        o_item.distance       = '0;
        o_item.over_threshold = 1'b0;
        if (i_step.meas_end) begin
            if (below_min) begin
                o_item.status = ST_BELOW_MIN;
            end else begin
                o_item.status         = ST_OK;
                o_item.distance       = dist_val;
                o_item.over_threshold = dist_val >= i_threshold;
            end
        end
    end

endmodule

// ----- design/ultrasonic_echo_ranger_core.sv -----
// Top level of the ultrasonic echo ranger: registers, beat flow and sequencer.
//
// Each input beat is one microsecond tick and yields exactly one result beat
// that gives the trigger level and measurement state after that tick. The
// block takes one beat every cycle while the output is not stalled; a beat
// held in the input register passes through the combinational sequencer and
// distance logic, and its result is loaded into the result register as the
// beat advances. A full result register that is not taken stalls the input
// side. Configuration writes take effect at once and are meant for idle
// periods only.
module ultrasonic_echo_ranger_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  uer_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output uer_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [uer_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import uer_pkg::*;

    logic [TRIG_W-1:0] r_trigger_width;
    logic [TMO_W-1:0]  r_timeout;
    logic [DIST_W-1:0] r_threshold;

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      adv;
    t_step     step;
    t_out_item res;

    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_width <= TRIG_RESET;
            r_timeout       <= TMO_RESET;
            r_threshold     <= THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TRIGGER_WIDTH: r_trigger_width <= i_cfg_wdata[TRIG_W-1:0];
                REG_TIMEOUT_TICKS: r_timeout       <= i_cfg_wdata[TMO_W-1:0];
                REG_DIST_THRESH:   r_threshold     <= i_cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= res;
        end
    end

    uer_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_item          (r_in_data),
        .i_trigger_width (r_trigger_width),
        .i_timeout       (r_timeout),
        .o_step          (step)
    );

    uer_dist u_dist (
        .i_step      (step),
        .i_threshold (r_threshold),
        .o_item      (res)
    );

endmodule

// ----- design/uer_checker.sv -----
// Port-level checks for the ultrasonic echo ranger and their bind.
module uer_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input uer_pkg::t_out_item o_out_data
);
    import uer_pkg::*;

    // A finished measurement always returns the sequencer to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res && !o_out_data.trigger_out)
        else $error("done beat shows busy or trigger");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.trigger_out |-> o_out_data.busy_res)
        else $error("trigger high while not busy");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |->
            o_out_data.status == ST_OK && o_out_data.distance == '0
            && !o_out_data.over_threshold)
        else $error("result fields set without done");

    a_fail_no_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res && o_out_data.status != ST_OK |->
            o_out_data.distance == '0 && !o_out_data.over_threshold)
        else $error("distance reported on a failed measurement");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
